@@ rtl/core/bsre_pkg.sv @@
`timescale 1ns / 1ps

package bsre_pkg;

    // Sizing of the basis row and the fixed-point format
    localparam int MAX_CTRL   = 32;
    localparam int MAX_ORDER  = 7;
    localparam int FRAC_BITS  = 15;
    localparam int VAL_W      = FRAC_BITS + 1;
    localparam int KNOT_DEPTH = MAX_CTRL + MAX_ORDER + 1;
    localparam int ADDR_W     = $clog2(KNOT_DEPTH);
    localparam int ORDER_W    = 3;
    localparam int CTRL_W     = 5;
    localparam int KK_W       = 4;
    localparam int PROD_W     = 2 * VAL_W;
    localparam int TERM_W     = PROD_W + 2;
    localparam int CIDX_W     = 4;
    localparam int CDATA_W    = 8;

    localparam logic [VAL_W-1:0] ONE_FX  = {1'b1, {FRAC_BITS{1'b0}}};
    localparam logic [VAL_W-1:0] VAL_MAX = '1;

    // Register indexes of the configuration port
    localparam logic [CIDX_W-1:0] CFG_ORDER = CIDX_W'(0);
    localparam logic [CIDX_W-1:0] CFG_LAST  = CIDX_W'(1);

    // Scratch row write data select
    localparam logic [1:0] WSEL_IND  = 2'd0;
    localparam logic [1:0] WSEL_ZERO = 2'd1;
    localparam logic [1:0] WSEL_SUM  = 2'd2;

    typedef struct packed {
        logic              knot_we;
        logic [ADDR_W-1:0] knot_raddr;
        logic [ADDR_W-1:0] scr_raddr;
        logic              scr_we;
        logic [ADDR_W-1:0] scr_waddr;
        logic [1:0]        scr_wsel;
        logic              ld_t;
        logic              ld_kprev;
        logic              ld_end;
        logic              ld_ka;
        logic              ld_kb;
        logic              ld_kc;
        logic              ld_kd;
        logic              ld_b0;
        logic              ld_b1;
        logic              mul_e;
        logic              ld_prod;
        logic              div_start;
        logic              ld_d;
        logic              ld_e;
        logic              clr_d;
        logic              clr_e;
        logic              out_load;
        logic              out_last;
        logic [CTRL_W-1:0] out_index;
    } cmd_t;

    typedef struct packed {
        logic d_ok;
        logic e_ok;
        logic div_done;
        logic out_free;
    } sts_t;

endpackage

@@ rtl/core/bsre_div.sv @@
`timescale 1ns / 1ps

module bsre_div (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    input  logic [bsre_pkg::PROD_W-1:0] dividend,
    input  logic [bsre_pkg::VAL_W-1:0]  divisor,
    output logic [bsre_pkg::PROD_W-1:0] quot,
    output logic                       done
);
    import bsre_pkg::*;

    localparam int CNT_W = $clog2(PROD_W);

    logic              busy_reg, busy_next;
    logic              done_reg, done_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic [PROD_W-1:0] dvd_reg, dvd_next;
    logic [VAL_W-1:0]  rem_reg, rem_next;
    logic [VAL_W-1:0]  dvs_reg, dvs_next;
    logic [VAL_W:0]    rem_shift;
    logic [VAL_W:0]    diff;

    // One quotient bit per cycle, restoring
    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        dvd_next  = dvd_reg;
        rem_next  = rem_reg;
        dvs_next  = dvs_reg;
        rem_shift = {rem_reg, dvd_reg[PROD_W-1]};
        diff      = rem_shift - {1'b0, dvs_reg};
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
            dvd_next  = dividend;
            rem_next  = '0;
            dvs_next  = divisor;
        end
        else if (busy_reg)
        begin
            if (rem_shift >= {1'b0, dvs_reg})
            begin
                rem_next = diff[VAL_W-1:0];
                dvd_next = {dvd_reg[PROD_W-2:0], 1'b1};
            end
            else
            begin
                rem_next = rem_shift[VAL_W-1:0];
                dvd_next = {dvd_reg[PROD_W-2:0], 1'b0};
            end
            cnt_next = cnt_reg + CNT_W'(1);
            if (cnt_reg == CNT_W'(PROD_W - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        dvd_reg <= dvd_next;
        rem_reg <= rem_next;
        dvs_reg <= dvs_next;
    end

    assign quot = dvd_reg;
    assign done = done_reg;

endmodule

@@ rtl/core/bsre_dp.sv @@
`timescale 1ns / 1ps

module bsre_dp (
    input  logic                       clk,
    input  logic                       rst_n,
    input  bsre_pkg::cmd_t             cmd,
    input  logic [bsre_pkg::ADDR_W-1:0] knot_index,
    input  logic [bsre_pkg::VAL_W-1:0]  knot_value,
    input  logic [bsre_pkg::VAL_W-1:0]  param_t,
    input  logic                       m_ready,
    output bsre_pkg::sts_t             sts,
    output logic                       m_valid,
    output logic [bsre_pkg::CTRL_W-1:0] m_index,
    output logic [bsre_pkg::VAL_W-1:0]  m_value,
    output logic                       m_last
);
    import bsre_pkg::*;

    logic [VAL_W-1:0]  knot_mem [KNOT_DEPTH];
    logic [VAL_W-1:0]  scr_mem  [KNOT_DEPTH];
    logic [VAL_W-1:0]  knot_rdata_reg;
    logic [VAL_W-1:0]  scr_rdata_reg;
    logic [VAL_W-1:0]  scr_wdata;

    logic [VAL_W-1:0]  t_reg, kprev_reg, ka_reg, kb_reg, kc_reg, kd_reg;
    logic [VAL_W-1:0]  b0_reg, b1_reg;
    logic              end_reg;
    logic [PROD_W-1:0] prod_reg;
    logic [VAL_W-1:0]  den_reg;
    logic              neg_reg;
    logic [TERM_W-1:0] d_reg, e_reg;

    logic [VAL_W:0]    num_s, den_s;
    logic [VAL_W:0]    num_neg, den_neg;
    logic [VAL_W-1:0]  num_mag, den_mag, b_sel;
    logic [PROD_W-1:0] quot;
    logic              div_done;
    logic [TERM_W-1:0] term;
    logic [TERM_W:0]   sum;

    logic              out_valid_reg;
    logic [CTRL_W-1:0] out_index_reg;
    logic [VAL_W-1:0]  out_value_reg;
    logic              out_last_reg;

    logic [VAL_W-1:0]  ind_val;
    logic [VAL_W-1:0]  sum_clamped;

    bsre_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.div_start),
        .dividend (prod_reg),
        .divisor  (den_reg),
        .quot     (quot),
        .done     (div_done)
    );

    // Order-one indicator over the span ending at the knot just read
    assign ind_val = ((t_reg >= kprev_reg) && (t_reg < knot_rdata_reg)) ? ONE_FX : '0;

    // Numerator and denominator of the selected term, then their magnitudes
    always_comb
    begin
        if (cmd.mul_e)
        begin
            num_s = {1'b0, kd_reg} - {1'b0, t_reg};
            den_s = {1'b0, kd_reg} - {1'b0, kb_reg};
            b_sel = b1_reg;
        end
        else
        begin
            num_s = {1'b0, t_reg} - {1'b0, ka_reg};
            den_s = {1'b0, kc_reg} - {1'b0, ka_reg};
            b_sel = b0_reg;
        end
        num_neg = -num_s;
        den_neg = -den_s;
        num_mag = num_s[VAL_W] ? num_neg[VAL_W-1:0] : num_s[VAL_W-1:0];
        den_mag = den_s[VAL_W] ? den_neg[VAL_W-1:0] : den_s[VAL_W-1:0];
    end

    // Signed quotient, truncated toward zero
    assign term = neg_reg ? (-{2'b00, quot}) : {2'b00, quot};

    // Sum both terms and clamp to the value range
    assign sum = {d_reg[TERM_W-1], d_reg} + {e_reg[TERM_W-1], e_reg};
    always_comb
    begin
        priority if (sum[TERM_W])
            sum_clamped = '0;
        else if (sum[TERM_W-1:VAL_W] != '0)
            sum_clamped = VAL_MAX;
        else
            sum_clamped = sum[VAL_W-1:0];
    end

    always_comb
    begin
        unique case (cmd.scr_wsel)
            WSEL_IND:  scr_wdata = ind_val;
            WSEL_SUM:  scr_wdata = sum_clamped;
            default:   scr_wdata = '0;
        endcase
    end

    // Knot store and scratch row, one write and one registered read each
    always_ff @(posedge clk)
    begin
        if (cmd.knot_we && ({1'b0, knot_index} < (ADDR_W+1)'(KNOT_DEPTH)))
            knot_mem[knot_index] <= knot_value;
        knot_rdata_reg <= knot_mem[cmd.knot_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (cmd.scr_we)
            scr_mem[cmd.scr_waddr] <= scr_wdata;
        scr_rdata_reg <= scr_mem[cmd.scr_raddr];
    end

    // Operand and term registers
    always_ff @(posedge clk)
    begin
        if (cmd.ld_t)
            t_reg <= param_t;
        if (cmd.ld_kprev)
            kprev_reg <= knot_rdata_reg;
        if (cmd.ld_end)
            end_reg <= (t_reg == knot_rdata_reg);
        if (cmd.ld_ka)
            ka_reg <= knot_rdata_reg;
        if (cmd.ld_kb)
            kb_reg <= knot_rdata_reg;
        if (cmd.ld_kc)
            kc_reg <= knot_rdata_reg;
        if (cmd.ld_kd)
            kd_reg <= knot_rdata_reg;
        if (cmd.ld_b0)
            b0_reg <= scr_rdata_reg;
        if (cmd.ld_b1)
            b1_reg <= scr_rdata_reg;
        if (cmd.ld_prod)
        begin
            prod_reg <= num_mag * b_sel;
            den_reg  <= den_mag;
            neg_reg  <= num_s[VAL_W] ^ den_s[VAL_W];
        end
        if (cmd.clr_d)
            d_reg <= '0;
        else if (cmd.ld_d)
            d_reg <= term;
        if (cmd.clr_e)
            e_reg <= '0;
        else if (cmd.ld_e)
            e_reg <= term;
    end

    // Output register: hold the item until taken
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (cmd.out_load)
            out_valid_reg <= 1'b1;
        else if (m_ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            out_index_reg <= cmd.out_index;
            out_last_reg  <= cmd.out_last;
            out_value_reg <= (cmd.out_last && end_reg) ? ONE_FX : scr_rdata_reg;
        end
    end

    assign sts.d_ok     = (b0_reg != '0) && (kc_reg != ka_reg);
    assign sts.e_ok     = (b1_reg != '0) && (kd_reg != kb_reg);
    assign sts.div_done = div_done;
    assign sts.out_free = !out_valid_reg || m_ready;

    assign m_valid = out_valid_reg;
    assign m_index = out_index_reg;
    assign m_value = out_value_reg;
    assign m_last  = out_last_reg;

endmodule

@@ rtl/core/bsre_ctrl.sv @@
`timescale 1ns / 1ps

module bsre_ctrl (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        s_valid,
    input  logic                        s_func,
    output logic                        s_ready,
    input  logic                        cfg_valid,
    input  logic [bsre_pkg::CIDX_W-1:0]  cfg_index,
    input  logic [bsre_pkg::CDATA_W-1:0] cfg_data,
    output logic                        cfg_ready,
    input  bsre_pkg::sts_t              sts,
    output bsre_pkg::cmd_t              cmd
);
    import bsre_pkg::*;

    localparam int ST_W = 5;
    localparam logic [ST_W-1:0] ST_IDLE    = 5'd0;
    localparam logic [ST_W-1:0] ST_O_RD0   = 5'd1;
    localparam logic [ST_W-1:0] ST_O_FIRST = 5'd2;
    localparam logic [ST_W-1:0] ST_O_STEP  = 5'd3;
    localparam logic [ST_W-1:0] ST_O_TAIL  = 5'd4;
    localparam logic [ST_W-1:0] ST_R_RD0   = 5'd5;
    localparam logic [ST_W-1:0] ST_R_RD1   = 5'd6;
    localparam logic [ST_W-1:0] ST_R_RD2   = 5'd7;
    localparam logic [ST_W-1:0] ST_R_RD3   = 5'd8;
    localparam logic [ST_W-1:0] ST_R_RD4   = 5'd9;
    localparam logic [ST_W-1:0] ST_R_MUL1  = 5'd10;
    localparam logic [ST_W-1:0] ST_R_DS1   = 5'd11;
    localparam logic [ST_W-1:0] ST_R_DW1   = 5'd12;
    localparam logic [ST_W-1:0] ST_R_MUL2  = 5'd13;
    localparam logic [ST_W-1:0] ST_R_DS2   = 5'd14;
    localparam logic [ST_W-1:0] ST_R_DW2   = 5'd15;
    localparam logic [ST_W-1:0] ST_R_WB    = 5'd16;
    localparam logic [ST_W-1:0] ST_X_RD    = 5'd17;
    localparam logic [ST_W-1:0] ST_X_LD    = 5'd18;

    logic [ST_W-1:0]    state_reg, state_next;
    logic [ADDR_W-1:0]  i_reg, i_next;
    logic [KK_W-1:0]    kk_reg, kk_next;
    logic [ORDER_W-1:0] order_reg;
    logic [CTRL_W-1:0]  last_reg;

    logic [ADDR_W-1:0]  m_cnt;
    logic [ADDR_W-1:0]  i_plus1;
    logic [ADDR_W-1:0]  kk_ext;
    logic [ADDR_W:0]    next_reach;
    logic               row_end;

    assign m_cnt      = ADDR_W'(last_reg) + ADDR_W'(order_reg) + ADDR_W'(1);
    assign i_plus1    = i_reg + ADDR_W'(1);
    assign kk_ext     = ADDR_W'(kk_reg);
    assign next_reach = {1'b0, i_plus1} + {1'b0, kk_ext};
    assign row_end    = (i_reg == ADDR_W'(last_reg));

    assign s_ready   = (state_reg == ST_IDLE);
    assign cfg_ready = 1'b1;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            order_reg <= ORDER_W'(3);
            last_reg  <= CTRL_W'(3);
        end
        else if (cfg_valid)
        begin
            priority if (cfg_index == CFG_ORDER)
                order_reg <= cfg_data[ORDER_W-1:0];
            else if (cfg_index == CFG_LAST)
                last_reg <= cfg_data[CTRL_W-1:0];
        end
    end

    // Sequence knot writes, the order-one pass, the recursion and the row readout
    always_comb
    begin
        cmd            = '0;
        cmd.knot_raddr = i_reg;
        cmd.scr_raddr  = i_reg;
        cmd.scr_waddr  = i_reg;
        cmd.scr_wsel   = WSEL_ZERO;
        cmd.out_index  = i_reg[CTRL_W-1:0];
        cmd.out_last   = row_end;
        state_next     = state_reg;
        i_next         = i_reg;
        kk_next        = kk_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (s_valid)
                begin
                    if (s_func)
                    begin
                        cmd.ld_t   = 1'b1;
                        state_next = ST_O_RD0;
                    end
                    else
                        cmd.knot_we = 1'b1;
                end
            end
            ST_O_RD0:
            begin
                cmd.knot_raddr = '0;
                i_next         = '0;
                state_next     = ST_O_FIRST;
            end
            ST_O_FIRST:
            begin
                cmd.ld_kprev   = 1'b1;
                cmd.knot_raddr = i_plus1;
                state_next     = ST_O_STEP;
            end
            ST_O_STEP:
            begin
                cmd.scr_we   = 1'b1;
                cmd.scr_wsel = WSEL_IND;
                cmd.ld_kprev = 1'b1;
                if (i_plus1 == m_cnt)
                begin
                    cmd.ld_end = 1'b1;
                    state_next = ST_O_TAIL;
                end
                else
                begin
                    i_next         = i_plus1;
                    cmd.knot_raddr = i_reg + ADDR_W'(2);
                end
            end
            ST_O_TAIL:
            begin
                cmd.scr_we    = 1'b1;
                cmd.scr_waddr = m_cnt;
                cmd.scr_wsel  = WSEL_ZERO;
                i_next        = '0;
                kk_next       = KK_W'(2);
                if (order_reg == '0)
                    state_next = ST_X_RD;
                else
                    state_next = ST_R_RD0;
            end
            ST_R_RD0:
            begin
                state_next = ST_R_RD1;
            end
            ST_R_RD1:
            begin
                cmd.ld_ka      = 1'b1;
                cmd.ld_b0      = 1'b1;
                cmd.knot_raddr = i_plus1;
                cmd.scr_raddr  = i_plus1;
                state_next     = ST_R_RD2;
            end
            ST_R_RD2:
            begin
                cmd.ld_kb      = 1'b1;
                cmd.ld_b1      = 1'b1;
                cmd.knot_raddr = i_reg + kk_ext - ADDR_W'(1);
                state_next     = ST_R_RD3;
            end
            ST_R_RD3:
            begin
                cmd.ld_kc      = 1'b1;
                cmd.knot_raddr = i_reg + kk_ext;
                state_next     = ST_R_RD4;
            end
            ST_R_RD4:
            begin
                cmd.ld_kd  = 1'b1;
                state_next = ST_R_MUL1;
            end
            ST_R_MUL1:
            begin
                if (sts.d_ok)
                begin
                    cmd.ld_prod = 1'b1;
                    state_next  = ST_R_DS1;
                end
                else
                begin
                    cmd.clr_d  = 1'b1;
                    state_next = ST_R_MUL2;
                end
            end
            ST_R_DS1:
            begin
                cmd.div_start = 1'b1;
                state_next    = ST_R_DW1;
            end
            ST_R_DW1:
            begin
                if (sts.div_done)
                begin
                    cmd.ld_d   = 1'b1;
                    state_next = ST_R_MUL2;
                end
            end
            ST_R_MUL2:
            begin
                cmd.mul_e = 1'b1;
                if (sts.e_ok)
                begin
                    cmd.ld_prod = 1'b1;
                    state_next  = ST_R_DS2;
                end
                else
                begin
                    cmd.clr_e  = 1'b1;
                    state_next = ST_R_WB;
                end
            end
            ST_R_DS2:
            begin
                cmd.div_start = 1'b1;
                state_next    = ST_R_DW2;
            end
            ST_R_DW2:
            begin
                if (sts.div_done)
                begin
                    cmd.ld_e   = 1'b1;
                    state_next = ST_R_WB;
                end
            end
            ST_R_WB:
            begin
                cmd.scr_we   = 1'b1;
                cmd.scr_wsel = WSEL_SUM;
                priority if (next_reach <= {1'b0, m_cnt})
                begin
                    i_next     = i_plus1;
                    state_next = ST_R_RD0;
                end
                else if (kk_reg <= KK_W'(order_reg))
                begin
                    i_next     = '0;
                    kk_next    = kk_reg + KK_W'(1);
                    state_next = ST_R_RD0;
                end
                else
                begin
                    i_next     = '0;
                    state_next = ST_X_RD;
                end
            end
            ST_X_RD:
            begin
                state_next = ST_X_LD;
            end
            ST_X_LD:
            begin
                if (sts.out_free)
                begin
                    cmd.out_load = 1'b1;
                    if (row_end)
                        state_next = ST_IDLE;
                    else
                    begin
                        i_next     = i_plus1;
                        state_next = ST_X_RD;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            i_reg     <= '0;
            kk_reg    <= '0;
        end
        else
        begin
            state_reg <= state_next;
            i_reg     <= i_next;
            kk_reg    <= kk_next;
        end
    end

endmodule

@@ rtl/core/bspline_basis_row_eval_top.sv @@
`timescale 1ns / 1ps

// B-spline basis row evaluator (Cox-de Boor recursion, unsigned Q1.15).
// Input channel s_*: tuser[0] selects the item kind. A write item (0) stores
// a knot. An evaluate item (1) carries t and yields the row N0..Nn on the
// output channel m_*, one item per basis index, tlast on index n.
// Config channel cfg_*: index 0 is the degree p, index 1 is the last control
// index n; cfg_ready is always high. Write it only while the block is idle.
// For an evaluate, with m = n + p + 1, the order-one pass fills scratch entries
// 0 to m - 1 and clears entry m; then come the recursion entries (the shared
// one-bit-per-cycle divider runs once per nonzero term, two terms per entry)
// and the readout. The input is not taken again until the last result of the
// row sits in the output register.
// Reset clears control state and loads p = 3, n = 3; the knot store and
// scratch row are not cleared and must be written before use.
// A stalled receiver holds the output register; the sequencer waits on it.
module bspline_basis_row_eval_top (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [39:0] s_tdata,   // knot_index[5:0], knot_value[21:6], param_t[37:22]
    input  logic [0:0]  s_tuser,   // func[0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,   // basis_index[4:0], basis_value[20:5]
    output logic        m_tlast,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [3:0]  cfg_index,
    input  logic [7:0]  cfg_data
);
    import bsre_pkg::*;

    cmd_t              cmd;
    sts_t              sts;
    logic [CTRL_W-1:0] m_index;
    logic [VAL_W-1:0]  m_value;

    bsre_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_valid   (s_tvalid),
        .s_func    (s_tuser[0]),
        .s_ready   (s_tready),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg_ready (cfg_ready),
        .sts       (sts),
        .cmd       (cmd)
    );

    bsre_dp u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .knot_index (s_tdata[5:0]),
        .knot_value (s_tdata[21:6]),
        .param_t    (s_tdata[37:22]),
        .m_ready    (m_tready),
        .sts        (sts),
        .m_valid    (m_tvalid),
        .m_index    (m_index),
        .m_value    (m_value),
        .m_last     (m_tlast)
    );

    assign m_tdata = {3'b000, m_value, m_index};

endmodule

@@ rtl/core/bsre_checker.sv @@
`timescale 1ns / 1ps

module bsre_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic [0:0]  s_tuser,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [23:0] m_tdata,
    input logic        m_tlast
);

    // Hold a stalled output item
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata) && $stable(m_tlast)))
        else $error("output item changed while stalled");

    // A knot write leaves the block ready for the next item
    a_write_ready: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready && !s_tuser[0]) |=> s_tready)
        else $error("knot write left the input blocked");

    // An evaluate occupies the block
    a_eval_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready && s_tuser[0]) |=> !s_tready)
        else $error("input ready right after an evaluate");

    // No new item while a row is still being read out
    a_row_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tready && !m_tlast) |-> !s_tready)
        else $error("input ready in the middle of a row");

endmodule

bind bspline_basis_row_eval_top bsre_checker u_bsre_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
);
